>>> rtl/ctsl_pkg.sv
// shared types and character constants for the statement lexer
package ctsl_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last;
  } result_t;

  typedef struct packed {
    logic in_string;
    logic in_comment;
    logic slash_pending;
    logic equal_seen;
    logic halted;
  } flags_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

>>> rtl/ctsl_if.sv
// valid/ready channel interfaces for characters in and results out
interface ctsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface ctsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

>>> rtl/config_text_statement_lexer_core.sv
// Configuration text statement lexer: takes one raw character per transfer and returns the
// cleaned statement text. Spaces and tabs outside strings and all comment text ('#' or '//'
// up to a line end) are dropped, a ';' outside strings closes the statement (kind 1), and a
// second '=' in one statement or a full statement store gives a parse error (kind 2), after
// which the block swallows all input until reset. A character goes into an input register,
// is decoded combinationally and its zero, one or two results go into a four-entry result queue
// whose head drives the output channel. With the output side ready the block takes one
// character per cycle; a character is held in the input register only while the result queue
// has fewer than two free slots, so a burst of double results slows the input to the rate at
// which results are taken.
module config_text_statement_lexer_core import ctsl_pkg::*; #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctsl_in_if.sink   in_i,
  ctsl_out_if.source out_o
);

  localparam int CntW = $clog2(BUFFER_BYTES + 1);

  // input register
  logic       hold_valid_q;
  logic [7:0] hold_char_q;

  // lexer state
  flags_t          flags_q, flags_d;
  logic [CntW-1:0] fill_q, fill_d;

  logic       room;
  logic       fire;
  logic [1:0] step_num;
  result_t    step_res0, step_res1, head;

  // decode the held character once the queue can take both results
  assign fire       = hold_valid_q && room;
  assign in_i.ready = !hold_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      hold_valid_q <= 1'b1;
    end else if (fire) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) hold_char_q <= in_i.in_char;
  end

  ctsl_step #(.BUFFER_BYTES(BUFFER_BYTES)) u_step (
    .char_i  (hold_char_q),
    .flags_i (flags_q),
    .fill_i  (fill_q),
    .flags_o (flags_d),
    .fill_o  (fill_d),
    .num_o   (step_num),
    .res0_o  (step_res0),
    .res1_o  (step_res1)
  );

  // state advances only when a character is actually decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      fill_q  <= '0;
    end else if (fire) begin
      flags_q <= flags_d;
      fill_q  <= fill_d;
    end
  end

  ctsl_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (fire ? step_num : 2'd0),
    .push0_i    (step_res0),
    .push1_i    (step_res1),
    .room_o     (room),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .head_o     (head)
  );

  // result transfer from the queue head
  assign out_o.out_byte = head.out_byte;
  assign out_o.kind     = head.kind;
  assign out_o.last     = head.last;

endmodule

>>> rtl/ctsl_step.sv
// next-state and result logic for one character
module ctsl_step import ctsl_pkg::*; #(
  parameter int BUFFER_BYTES = 1024,
  localparam int CntW = $clog2(BUFFER_BYTES + 1)
) (
  input  logic [7:0]      char_i,
  input  flags_t          flags_i,
  input  logic [CntW-1:0] fill_i,
  output flags_t          flags_o,
  output logic [CntW-1:0] fill_o,
  output logic [1:0]      num_o,
  output result_t         res0_o,
  output result_t         res1_o
);

  logic    pre_slash;
  logic    m_valid;
  logic    m_char;
  logic    m_end;
  result_t m_res;
  flags_t  f;

  always_comb begin
    f         = flags_i;
    pre_slash = 1'b0;
    m_valid   = 1'b0;
    m_char    = 1'b0;
    m_end     = 1'b0;
    m_res     = '{out_byte: 8'h00, kind: KIND_CHAR, last: 1'b0};
    fill_o    = fill_i;
    num_o     = 2'd0;
    res0_o    = m_res;
    res1_o    = m_res;

    if (flags_i.halted) begin
      num_o = 2'd0;
    end else if (fill_i >= CntW'(BUFFER_BYTES - 1)) begin
      // statement store full
      f.halted = 1'b1;
      num_o    = 2'd1;
      res0_o   = '{out_byte: 8'h00, kind: KIND_ERROR, last: 1'b1};
    end else begin
      if (flags_i.slash_pending && char_i != CH_SLASH) begin
        pre_slash       = 1'b1;
        f.slash_pending = 1'b0;
      end
      unique case (char_i)
        CH_QUOTE: begin
          if (!flags_i.in_comment) begin
            f.in_string = !flags_i.in_string;
            m_char      = 1'b1;
          end
        end
        CH_SEMI: begin
          if (!flags_i.in_string && !flags_i.in_comment) begin
            m_end        = 1'b1;
            f.equal_seen = 1'b0;
          end else if (flags_i.in_string) begin
            m_char = 1'b1;
          end
        end
        CH_SLASH: begin
          if (!flags_i.in_string && !flags_i.in_comment) begin
            if (flags_i.slash_pending) begin
              f.in_comment    = 1'b1;
              f.slash_pending = 1'b0;
            end else begin
              f.slash_pending = 1'b1;
            end
          end else if (!flags_i.in_comment) begin
            m_char = 1'b1;
          end
        end
        CH_LF, CH_CR: begin
          f.in_string     = 1'b0;
          f.in_comment    = 1'b0;
          f.slash_pending = 1'b0;
        end
        CH_SPACE, CH_TAB: begin
          if (flags_i.in_string) m_char = 1'b1;
        end
        CH_HASH: begin
          if (!flags_i.in_string) f.in_comment = 1'b1;
          else m_char = 1'b1;
        end
        default: begin
          if (!flags_i.in_comment) begin
            if (char_i == CH_EQUAL && flags_i.equal_seen) begin
              f.halted = 1'b1;
              m_valid  = 1'b1;
              m_res    = '{out_byte: 8'h00, kind: KIND_ERROR, last: 1'b0};
            end else begin
              if (char_i == CH_EQUAL) f.equal_seen = 1'b1;
              m_char = 1'b1;
            end
          end
        end
      endcase

      if (m_char) begin
        m_valid = 1'b1;
        m_res   = '{out_byte: char_i, kind: KIND_CHAR, last: 1'b0};
      end else if (m_end) begin
        m_valid = 1'b1;
        m_res   = '{out_byte: 8'h00, kind: KIND_END, last: 1'b0};
      end
      m_res.last = 1'b1;

      if (m_end) fill_o = '0;
      else fill_o = fill_i + CntW'(pre_slash) + CntW'(m_char);

      if (pre_slash) begin
        res0_o = '{out_byte: CH_SLASH, kind: KIND_CHAR, last: !m_valid};
        res1_o = m_res;
        num_o  = m_valid ? 2'd2 : 2'd1;
      end else begin
        res0_o = m_res;
        num_o  = m_valid ? 2'd1 : 2'd0;
      end
    end
    flags_o = f;
  end

endmodule

>>> rtl/ctsl_result_fifo.sv
// four-entry result queue taking up to two results per cycle
module ctsl_result_fifo import ctsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    head_o
);

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // two free slots needed before a character can be processed
  assign room_o  = (count_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) mem_q[wr_ptr_q] <= push0_i;
    if (push_num_i == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_num_i;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, push_num_i} - {2'b00, pop};
    end
  end

endmodule
